// ===== hw/rtl/rti_pkg.sv =====
// ----------------------------------------------------------------------------
// rti_pkg
// shared types, constants and single-precision helpers for the ray/triangle
// intersection pipeline
// ----------------------------------------------------------------------------
package rti_pkg;

   // register file
   localparam int NumRegs  = 7;
   localparam int RegIdxW  = 3;
   localparam int FpW      = 32;

   typedef enum logic [RegIdxW-1:0] {
      REG_ORG_X    = 3'd0,
      REG_ORG_Y    = 3'd1,
      REG_ORG_Z    = 3'd2,
      REG_DIR_X    = 3'd3,
      REG_DIR_Y    = 3'd4,
      REG_DIR_Z    = 3'd5,
      REG_MAX_DIST = 3'd6
   } reg_idx_type;

   // float constants
   localparam logic [FpW-1:0] FpZero    = 32'h0000_0000;
   localparam logic [FpW-1:0] FpOne     = 32'h3F80_0000;
   localparam logic [FpW-1:0] FpQnan    = 32'h7FC0_0000;
   localparam logic [FpW-1:0] DetEps    = 32'h3586_37BD;
   localparam logic [FpW-1:0] DetEpsNeg = 32'hB586_37BD;

   // unit latencies in cycles
   localparam int AddLat = 3;
   localparam int MulLat = 3;
   localparam int RcpLat = 12;

   // unrounded intermediate: leading one at bit 47 after normalising
   localparam int NormW = 48;

   typedef struct packed {
      logic               sgn;
      logic               nan;
      logic               inf;
      logic               zero;
      logic signed [11:0] ex;
      logic [NormW-1:0]   man;
   } fp_mid_type;

   function automatic logic fp_is_nan(input logic [FpW-1:0] x);
      return (x[30:23] == 8'hFF) && (x[22:0] != 23'd0);
   endfunction

   function automatic logic fp_is_inf(input logic [FpW-1:0] x);
      return (x[30:23] == 8'hFF) && (x[22:0] == 23'd0);
   endfunction

   function automatic logic fp_is_zero(input logic [FpW-1:0] x);
      return x[30:0] == 31'd0;
   endfunction

   // leading zero count over the intermediate word
   function automatic logic [5:0] lzc48(input logic [NormW-1:0] v);
      logic [5:0] n;
      logic       found;
      n     = 6'd48;
      found = 1'b0;
      for (int i = NormW - 1; i >= 0; i--) begin
         if (!found && v[i]) begin
            n     = 6'(NormW - 1 - i);
            found = 1'b1;
         end
      end
      return n;
   endfunction

   // shift leading one to the top and adjust exponent
   function automatic fp_mid_type fp_norm(input fp_mid_type m);
      fp_mid_type r;
      logic [5:0] lz;
      lz    = lzc48(m.man);
      r     = m;
      r.man = m.man << lz;
      r.ex  = m.ex - $signed({6'd0, lz});
      return r;
   endfunction

   // denormalise if needed, round to nearest even and pack
   function automatic logic [FpW-1:0] fp_round(input fp_mid_type m);
      logic [11:0]      sh;
      logic [NormW-1:0] nd;
      logic [NormW-1:0] mask;
      logic             st;
      logic [7:0]       fld;
      logic             inc;
      logic [30:0]      pk;
      nd   = m.man;
      fld  = m.ex[7:0];
      sh   = 12'd0;
      mask = '0;
      st   = 1'b0;
      if (m.nan) begin
         return FpQnan;
      end
      if (m.inf || (m.ex >= 12'sd255)) begin
         return {m.sgn, 8'hFF, 23'd0};
      end
      if (m.zero) begin
         return {m.sgn, 31'd0};
      end
      if (m.ex < 12'sd1) begin
         sh = 12'(12'sd1 - m.ex);
         if (sh > 12'd48) begin
            sh = 12'd48;
         end
         mask  = ~({NormW{1'b1}} << sh);
         st    = |(m.man & mask);
         nd    = m.man >> sh;
         nd[0] = nd[0] | st;
         fld   = 8'd0;
      end
      inc = nd[23] & ((|nd[22:0]) | nd[24]);
      pk  = {fld, nd[46:24]} + {30'd0, inc};
      return {m.sgn, pk};
   endfunction

   // ieee less-than, false on nan, zeros compare equal
   function automatic logic fp_lt(input logic [FpW-1:0] a, input logic [FpW-1:0] b);
      if (fp_is_nan(a) || fp_is_nan(b)) begin
         return 1'b0;
      end
      if (fp_is_zero(a) && fp_is_zero(b)) begin
         return 1'b0;
      end
      if (a[31] != b[31]) begin
         return a[31];
      end
      if (a[31]) begin
         return a[30:0] > b[30:0];
      end
      return a[30:0] < b[30:0];
   endfunction

   // ieee less-or-equal
   function automatic logic fp_le(input logic [FpW-1:0] a, input logic [FpW-1:0] b);
      if (fp_is_nan(a) || fp_is_nan(b)) begin
         return 1'b0;
      end
      if ((a == b) || (fp_is_zero(a) && fp_is_zero(b))) begin
         return 1'b1;
      end
      return fp_lt(a, b);
   endfunction

endpackage

// ===== hw/rtl/rti_delay.sv =====
// ----------------------------------------------------------------------------
// rti_delay
// enable-gated shift line that keeps side data in step with the float units
// ----------------------------------------------------------------------------
module rti_delay #(
   parameter int Width = 32,
   parameter int Depth = 1
) (
   input  logic             clock,
   input  logic             en,
   input  logic [Width-1:0] d,
   output logic [Width-1:0] q
);

   logic [Width-1:0] tap_ff [Depth];

   // shift on every advancing cycle
   always_ff @(posedge clock) begin
      if (en) begin
         tap_ff[0] <= d;
         for (int i = 1; i < Depth; i++) begin
            tap_ff[i] <= tap_ff[i-1];
         end
      end
   end

   assign q = tap_ff[Depth-1];

endmodule

// ===== hw/rtl/rti_fadd.sv =====
// ----------------------------------------------------------------------------
// rti_fadd
// three-stage single-precision adder/subtractor, round to nearest even
// ----------------------------------------------------------------------------
module rti_fadd (
   input  logic        clock,
   input  logic        en,
   input  logic        op_sub,
   input  logic [31:0] a,
   input  logic [31:0] b,
   output logic [31:0] res
);

   rti_pkg::fp_mid_type align_in, align_ff, norm_ff;
   logic [31:0] res_ff;

   logic [31:0] y, big, lit;
   logic        swap, eff;
   logic [7:0]  eb, el, d;
   logic [23:0] mb, ml;
   logic [26:0] b27, l27, ls;
   logic        st;
   logic [27:0] sum;

   // align smaller operand and add
   always_comb begin
      y    = {b[31] ^ op_sub, b[30:0]};
      swap = a[30:0] < y[30:0];
      big  = swap ? y : a;
      lit  = swap ? a : y;
      eb   = (big[30:23] == 8'd0) ? 8'd1 : big[30:23];
      el   = (lit[30:23] == 8'd0) ? 8'd1 : lit[30:23];
      mb   = {big[30:23] != 8'd0, big[22:0]};
      ml   = {lit[30:23] != 8'd0, lit[22:0]};
      d    = eb - el;
      b27  = {mb, 3'b000};
      l27  = {ml, 3'b000};
      if (d >= 8'd27) begin
         ls = 27'd0;
         st = |ml;
      end else begin
         ls = l27 >> d;
         st = |(l27 & ~(27'h7FF_FFFF << d));
      end
      ls[0] = ls[0] | st;
      eff   = big[31] ^ lit[31];
      sum   = eff ? ({1'b0, b27} - {1'b0, ls}) : ({1'b0, b27} + {1'b0, ls});
      align_in.nan  = rti_pkg::fp_is_nan(a) | rti_pkg::fp_is_nan(y)
                    | (rti_pkg::fp_is_inf(a) & rti_pkg::fp_is_inf(y) & eff);
      align_in.inf  = rti_pkg::fp_is_inf(a) | rti_pkg::fp_is_inf(y);
      align_in.zero = (sum == 28'd0);
      align_in.sgn  = ((sum == 28'd0) && eff) ? 1'b0 : big[31];
      align_in.ex   = $signed({4'd0, eb}) + 12'sd1;
      align_in.man  = {sum, 20'd0};
   end

   // pipeline registers
   always_ff @(posedge clock) begin
      if (en) begin
         align_ff <= align_in;
         norm_ff  <= rti_pkg::fp_norm(align_ff);
         res_ff   <= rti_pkg::fp_round(norm_ff);
      end
   end

   assign res = res_ff;

endmodule

// ===== hw/rtl/rti_fmul.sv =====
// ----------------------------------------------------------------------------
// rti_fmul
// three-stage single-precision multiplier, round to nearest even
// ----------------------------------------------------------------------------
module rti_fmul (
   input  logic        clock,
   input  logic        en,
   input  logic [31:0] a,
   input  logic [31:0] b,
   output logic [31:0] res
);

   rti_pkg::fp_mid_type prod_in, prod_ff, norm_ff;
   logic [31:0] res_ff;

   logic [7:0]  ea, eb;
   logic [23:0] ma, mb;

   // significand product and exponent sum
   always_comb begin
      ea = (a[30:23] == 8'd0) ? 8'd1 : a[30:23];
      eb = (b[30:23] == 8'd0) ? 8'd1 : b[30:23];
      ma = {a[30:23] != 8'd0, a[22:0]};
      mb = {b[30:23] != 8'd0, b[22:0]};
      prod_in.sgn  = a[31] ^ b[31];
      prod_in.nan  = rti_pkg::fp_is_nan(a) | rti_pkg::fp_is_nan(b)
                   | (rti_pkg::fp_is_inf(a) & rti_pkg::fp_is_zero(b))
                   | (rti_pkg::fp_is_zero(a) & rti_pkg::fp_is_inf(b));
      prod_in.inf  = rti_pkg::fp_is_inf(a) | rti_pkg::fp_is_inf(b);
      prod_in.zero = rti_pkg::fp_is_zero(a) | rti_pkg::fp_is_zero(b);
      prod_in.ex   = $signed({4'd0, ea}) + $signed({4'd0, eb}) - 12'sd126;
      prod_in.man  = ma * mb;
   end

   // pipeline registers
   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff <= prod_in;
         norm_ff <= rti_pkg::fp_norm(prod_ff);
         res_ff  <= rti_pkg::fp_round(norm_ff);
      end
   end

   assign res = res_ff;

endmodule

// ===== hw/rtl/rti_frcp.sv =====
// ----------------------------------------------------------------------------
// rti_frcp
// pipelined single-precision reciprocal: restoring division of one by the
// significand, three quotient bits per stage, then normalise and round
// ----------------------------------------------------------------------------
module rti_frcp (
   input  logic        clock,
   input  logic        en,
   input  logic [31:0] a,
   output logic [31:0] res
);

   localparam int QuoW     = 27;
   localparam int StepBits = 3;
   localparam int DivSteps = QuoW / StepBits;

   typedef struct packed {
      logic [23:0]     rem;
      logic [QuoW-1:0] quo;
   } div_state_type;

   // a few restoring steps on the partial remainder
   function automatic div_state_type div_step(input div_state_type s, input logic [23:0] dv);
      div_state_type r;
      logic [24:0]   t;
      r = s;
      for (int k = 0; k < StepBits; k++) begin
         t     = {r.rem, 1'b0};
         r.quo = {r.quo[QuoW-2:0], 1'b0};
         if (t >= {1'b0, dv}) begin
            t        = t - {1'b0, dv};
            r.quo[0] = 1'b1;
         end
         r.rem = t[23:0];
      end
      return r;
   endfunction

   div_state_type       div_ff  [DivSteps+1];
   logic [23:0]         dvs_ff  [DivSteps+1];
   rti_pkg::fp_mid_type meta_ff [DivSteps+1];
   rti_pkg::fp_mid_type meta_in, quo_mid, norm_ff;
   logic [31:0]         res_ff;

   // unpack divisor, exponent of the quotient and special cases
   always_comb begin
      meta_in.sgn  = a[31];
      meta_in.nan  = rti_pkg::fp_is_nan(a);
      meta_in.inf  = rti_pkg::fp_is_zero(a);
      meta_in.zero = rti_pkg::fp_is_inf(a);
      meta_in.ex   = 12'sd254 - $signed({4'd0, a[30:23]});
      meta_in.man  = '0;
   end

   // quotient with sticky remainder into the intermediate format
   always_comb begin
      quo_mid        = meta_ff[DivSteps];
      quo_mid.man    = {div_ff[DivSteps].quo, 21'd0};
      quo_mid.man[0] = div_ff[DivSteps].rem != 24'd0;
   end

   // division stages
   always_ff @(posedge clock) begin
      if (en) begin
         div_ff[0].rem <= 24'h40_0000;
         div_ff[0].quo <= '0;
         dvs_ff[0]     <= {a[30:23] != 8'd0, a[22:0]};
         meta_ff[0]    <= meta_in;
         for (int i = 1; i <= DivSteps; i++) begin
            div_ff[i]  <= div_step(div_ff[i-1], dvs_ff[i-1]);
            dvs_ff[i]  <= dvs_ff[i-1];
            meta_ff[i] <= meta_ff[i-1];
         end
         norm_ff <= rti_pkg::fp_norm(quo_mid);
         res_ff  <= rti_pkg::fp_round(norm_ff);
      end
   end

   assign res = res_ff;

endmodule

// ===== hw/rtl/ray_triangle_intersect_top.sv =====
// ----------------------------------------------------------------------------
// ray_triangle_intersect_top
// two-sided ray/triangle hit test in single precision, one triangle per beat
// ----------------------------------------------------------------------------
//  channel | direction | handshake            | payload
//  req     | in        | req_valid/req_stall  | vertex a, b, c (nine floats)
//  rsp     | out       | rsp_valid/rsp_stall  | hit
//  csr     | in        | csr_wr_en            | csr_idx, csr_wr_data
//
//  one triangle enters per cycle while req_stall is low; a result goes from
//  the input register via hit_ff to the output register. the depth is set
//  by the reciprocal unit and the chain of dependent adds and multiplies.
//  reset clears the ray registers to +0 and empties the pipeline.
//  a stalled result is held and one more result lands in a skid register;
//  the pipeline then freezes and req_stall is raised until the skid drains.
// ----------------------------------------------------------------------------
module ray_triangle_intersect_top (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [31:0]                 req_vertex_a_x,
   input  logic [31:0]                 req_vertex_a_y,
   input  logic [31:0]                 req_vertex_a_z,
   input  logic [31:0]                 req_vertex_b_x,
   input  logic [31:0]                 req_vertex_b_y,
   input  logic [31:0]                 req_vertex_b_z,
   input  logic [31:0]                 req_vertex_c_x,
   input  logic [31:0]                 req_vertex_c_y,
   input  logic [31:0]                 req_vertex_c_z,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic                        rsp_hit,
   input  logic                        csr_wr_en,
   input  logic [rti_pkg::RegIdxW-1:0] csr_idx,
   input  logic [31:0]                 csr_wr_data
);

   // stage timing, counted from the input register
   localparam int TEdge  = rti_pkg::AddLat;
   localparam int TCross = TEdge + rti_pkg::MulLat + rti_pkg::AddLat;
   localparam int TDot   = TCross + rti_pkg::MulLat + 2 * rti_pkg::AddLat;
   localparam int TInv   = TDot + rti_pkg::RcpLat;
   localparam int TBary  = TInv + rti_pkg::MulLat;
   localparam int TUv    = TBary + rti_pkg::AddLat;
   localparam int THit   = TUv + 1;

   logic en;

   // ray registers
   logic [31:0] cfg_ff [rti_pkg::NumRegs];
   logic [31:0] org [3];
   logic [31:0] dir [3];
   logic [31:0] tmax;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < rti_pkg::NumRegs; i++) begin
            cfg_ff[i] <= rti_pkg::FpZero;
         end
      end else if (csr_wr_en) begin
         case (csr_idx)
            rti_pkg::REG_ORG_X:    cfg_ff[rti_pkg::REG_ORG_X]    <= csr_wr_data;
            rti_pkg::REG_ORG_Y:    cfg_ff[rti_pkg::REG_ORG_Y]    <= csr_wr_data;
            rti_pkg::REG_ORG_Z:    cfg_ff[rti_pkg::REG_ORG_Z]    <= csr_wr_data;
            rti_pkg::REG_DIR_X:    cfg_ff[rti_pkg::REG_DIR_X]    <= csr_wr_data;
            rti_pkg::REG_DIR_Y:    cfg_ff[rti_pkg::REG_DIR_Y]    <= csr_wr_data;
            rti_pkg::REG_DIR_Z:    cfg_ff[rti_pkg::REG_DIR_Z]    <= csr_wr_data;
            rti_pkg::REG_MAX_DIST: cfg_ff[rti_pkg::REG_MAX_DIST] <= csr_wr_data;
            default: ;
         endcase
      end
   end

   assign org[0] = cfg_ff[rti_pkg::REG_ORG_X];
   assign org[1] = cfg_ff[rti_pkg::REG_ORG_Y];
   assign org[2] = cfg_ff[rti_pkg::REG_ORG_Z];
   assign dir[0] = cfg_ff[rti_pkg::REG_DIR_X];
   assign dir[1] = cfg_ff[rti_pkg::REG_DIR_Y];
   assign dir[2] = cfg_ff[rti_pkg::REG_DIR_Z];
   assign tmax   = cfg_ff[rti_pkg::REG_MAX_DIST];

   // input register and valid chain
   logic [31:0] va_ff [3];
   logic [31:0] vb_ff [3];
   logic [31:0] vc_ff [3];
   logic [THit:0] vld_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         va_ff[0] <= req_vertex_a_x;
         va_ff[1] <= req_vertex_a_y;
         va_ff[2] <= req_vertex_a_z;
         vb_ff[0] <= req_vertex_b_x;
         vb_ff[1] <= req_vertex_b_y;
         vb_ff[2] <= req_vertex_b_z;
         vc_ff[0] <= req_vertex_c_x;
         vc_ff[1] <= req_vertex_c_y;
         vc_ff[2] <= req_vertex_c_z;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[THit-1:0], req_valid};
      end
   end

   // edges and offset from vertex a
   logic [31:0] e1 [3];
   logic [31:0] e2 [3];
   logic [31:0] sv [3];
   logic [31:0] e1_d [3];
   logic [31:0] e2_d [3];
   logic [31:0] sv_d [3];
   logic [31:0] pv [3];
   logic [31:0] qv [3];

   for (genvar i = 0; i < 3; i++) begin : g_edge
      rti_fadd u_e1 (.clock, .en, .op_sub(1'b1), .a(vc_ff[i]), .b(va_ff[i]), .res(e1[i]));
      rti_fadd u_e2 (.clock, .en, .op_sub(1'b1), .a(vb_ff[i]), .b(va_ff[i]), .res(e2[i]));
      rti_fadd u_sv (.clock, .en, .op_sub(1'b1), .a(org[i]), .b(va_ff[i]), .res(sv[i]));

      rti_delay #(.Width(32), .Depth(TCross - TEdge)) u_e1_d (
         .clock, .en, .d(e1[i]), .q(e1_d[i]));
      rti_delay #(.Width(32), .Depth(TCross - TEdge)) u_e2_d (
         .clock, .en, .d(e2[i]), .q(e2_d[i]));
      rti_delay #(.Width(32), .Depth(TCross - TEdge)) u_sv_d (
         .clock, .en, .d(sv[i]), .q(sv_d[i]));
   end

   // cross products p = dir x e2 and q = s x e1
   for (genvar i = 0; i < 3; i++) begin : g_cross
      logic [31:0] pm0, pm1, qm0, qm1;
      rti_fmul u_pm0 (.clock, .en, .a(dir[(i+1)%3]), .b(e2[(i+2)%3]), .res(pm0));
      rti_fmul u_pm1 (.clock, .en, .a(dir[(i+2)%3]), .b(e2[(i+1)%3]), .res(pm1));
      rti_fadd u_p (.clock, .en, .op_sub(1'b1), .a(pm0), .b(pm1), .res(pv[i]));
      rti_fmul u_qm0 (.clock, .en, .a(sv[(i+1)%3]), .b(e1[(i+2)%3]), .res(qm0));
      rti_fmul u_qm1 (.clock, .en, .a(sv[(i+2)%3]), .b(e1[(i+1)%3]), .res(qm1));
      rti_fadd u_q (.clock, .en, .op_sub(1'b1), .a(qm0), .b(qm1), .res(qv[i]));
   end

   // four dot products: det, u, v and t before scaling
   logic [31:0] dot_x [4][3];
   logic [31:0] dot_y [4][3];
   logic [31:0] dot_r [4];

   for (genvar k = 0; k < 3; k++) begin : g_dot_in
      assign dot_x[0][k] = e1_d[k];
      assign dot_y[0][k] = pv[k];
      assign dot_x[1][k] = sv_d[k];
      assign dot_y[1][k] = pv[k];
      assign dot_x[2][k] = dir[k];
      assign dot_y[2][k] = qv[k];
      assign dot_x[3][k] = e2_d[k];
      assign dot_y[3][k] = qv[k];
   end

   for (genvar d = 0; d < 4; d++) begin : g_dot
      logic [31:0] prod [3];
      logic [31:0] sum01, prod2_d;
      for (genvar k = 0; k < 3; k++) begin : g_term
         rti_fmul u_m (.clock, .en, .a(dot_x[d][k]), .b(dot_y[d][k]), .res(prod[k]));
      end
      rti_fadd u_s01 (.clock, .en, .op_sub(1'b0), .a(prod[0]), .b(prod[1]), .res(sum01));
      rti_delay #(.Width(32), .Depth(rti_pkg::AddLat)) u_p2_d (
         .clock, .en, .d(prod[2]), .q(prod2_d));
      rti_fadd u_s (.clock, .en, .op_sub(1'b0), .a(sum01), .b(prod2_d), .res(dot_r[d]));
   end

   // determinant test and reciprocal
   logic        det_rej, det_rej_d;
   logic [31:0] inv;
   logic [31:0] raw_d [3];

   assign det_rej = rti_pkg::fp_lt(rti_pkg::DetEpsNeg, dot_r[0])
                  & rti_pkg::fp_lt(dot_r[0], rti_pkg::DetEps);

   rti_delay #(.Width(1), .Depth(TUv - TDot)) u_det_d (
      .clock, .en, .d(det_rej), .q(det_rej_d));

   rti_frcp u_rcp (.clock, .en, .a(dot_r[0]), .res(inv));

   for (genvar k = 0; k < 3; k++) begin : g_raw
      rti_delay #(.Width(32), .Depth(rti_pkg::RcpLat)) u_raw_d (
         .clock, .en, .d(dot_r[k+1]), .q(raw_d[k]));
   end

   // barycentrics and distance: u, v, t
   logic [31:0] bary [3];
   logic [31:0] uv;

   for (genvar k = 0; k < 3; k++) begin : g_scale
      rti_fmul u_sc (.clock, .en, .a(raw_d[k]), .b(inv), .res(bary[k]));
   end

   rti_fadd u_uv (.clock, .en, .op_sub(1'b0), .a(bary[0]), .b(bary[1]), .res(uv));

   // range tests, held until u+v is ready
   logic [3:0] flags, flags_d;

   assign flags[0] = rti_pkg::fp_lt(bary[0], rti_pkg::FpZero)
                   | rti_pkg::fp_lt(rti_pkg::FpOne, bary[0]);
   assign flags[1] = rti_pkg::fp_lt(bary[1], rti_pkg::FpZero);
   assign flags[2] = rti_pkg::fp_lt(bary[2], rti_pkg::FpZero);
   assign flags[3] = rti_pkg::fp_le(bary[2], tmax);

   rti_delay #(.Width(4), .Depth(TUv - TBary)) u_flags_d (
      .clock, .en, .d(flags), .q(flags_d));

   // final decision
   logic hit_in, hit_ff;

   assign hit_in = !det_rej_d & !flags_d[0] & !flags_d[1]
                 & !rti_pkg::fp_lt(rti_pkg::FpOne, uv) & !flags_d[2] & flags_d[3];

   always_ff @(posedge clock) begin
      if (en) begin
         hit_ff <= hit_in;
      end
   end

   // output register with skid
   logic out_vld_ff, out_hit_ff, skid_vld_ff, skid_hit_ff;
   logic take;

   assign take = out_vld_ff & !rsp_stall;
   assign en   = !skid_vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff  <= 1'b0;
         skid_vld_ff <= 1'b0;
      end else if (!out_vld_ff || take) begin
         out_vld_ff  <= skid_vld_ff | vld_ff[THit];
         skid_vld_ff <= 1'b0;
      end else if (vld_ff[THit]) begin
         skid_vld_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (!out_vld_ff || take) begin
         out_hit_ff <= skid_vld_ff ? skid_hit_ff : hit_ff;
      end else if (en) begin
         skid_hit_ff <= hit_ff;
      end
   end

   assign req_stall = skid_vld_ff;
   assign rsp_valid = out_vld_ff;
   assign rsp_hit   = out_hit_ff;

   // checks
   a_skid_fill: assert property (@(posedge clock) disable iff (reset)
      $rose(skid_vld_ff) |-> $past(out_vld_ff && rsp_stall))
      else $error("skid filled while output was free");

   a_skid_has_out: assert property (@(posedge clock) disable iff (reset)
      skid_vld_ff |-> out_vld_ff)
      else $error("skid beat held with empty output register");

   a_freeze: assert property (@(posedge clock) disable iff (reset)
      skid_vld_ff |=> $stable(vld_ff))
      else $error("pipeline moved while skid was full");

endmodule
